// File: rtl/core/bf16rem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf16rem_pkg - shared types and constants of the bfloat16 remainder unit
// Command and status words between controller and datapath, result select
// codes and the widths of the working registers.
// ----------------------------------------------------------------------------
package bf16rem_pkg;

  // quiet NaN returned for every invalid operation
  localparam logic [15:0] QNAN      = 16'h7FC0;
  localparam logic [14:0] INF_MAG   = 15'h7F80;
  // working register of the add path: 8-bit divisor shifted by up to 40
  localparam int          DW        = 49;
  // offset between the top byte of the working register and bit 0
  localparam logic [8:0]  TOP_OFS   = 9'd41;
  localparam logic [8:0]  MAX_SHIFT = 9'd40;

  typedef enum logic [1:0] {
    RES_SPECIAL = 2'd0,
    RES_ZERO    = 2'd1,
    RES_DIVISOR = 2'd2,
    RES_ENGINE  = 2'd3
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     rem_init;
    logic     rem_step;
    logic     eng_load_mr;
    logic     eng_load_mb;
    logic     shift;
    logic     sub;
    logic     norm;
    logic     out_load;
    res_sel_t res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic special;
    logic rem_done;
    logic mr_zero;
    logic need_add;
    logic k_big;
    logic shift_done;
    logic norm_done;
  } dp_sts_t;

endpackage

// File: rtl/core/bf16rem_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf16rem_ctrl - sequencer of the bfloat16 remainder unit
// Steps the datapath through decode, bit-serial remainder, divisor add,
// normalisation and rounding, and owns the handshake of both channels.
// ----------------------------------------------------------------------------
module bf16rem_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  bf16rem_pkg::dp_sts_t sts,
  output bf16rem_pkg::dp_cmd_t cmd
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_PREP  = 8'b00000010,
    ST_REM   = 8'b00000100,
    ST_SEL   = 8'b00001000,
    ST_SHIFT = 8'b00010000,
    ST_SUB   = 8'b00100000,
    ST_NORM  = 8'b01000000,
    ST_FIN   = 8'b10000000
  } state_t;

  state_t                state_r, state_nxt;
  bf16rem_pkg::res_sel_t kind_r, kind_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    cmd         = '0;
    cmd.res_sel = kind_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        if (sts.special) begin
          kind_nxt  = bf16rem_pkg::RES_SPECIAL;
          state_nxt = ST_FIN;
        end else begin
          cmd.rem_init = 1'b1;
          state_nxt    = ST_REM;
        end
      end
      ST_REM: begin
        if (sts.rem_done) state_nxt = ST_SEL;
        else cmd.rem_step = 1'b1;
      end
      ST_SEL: begin
        if (sts.mr_zero) begin
          kind_nxt  = bf16rem_pkg::RES_ZERO;
          state_nxt = ST_FIN;
        end else if (!sts.need_add) begin
          cmd.eng_load_mr = 1'b1;
          kind_nxt        = bf16rem_pkg::RES_ENGINE;
          state_nxt       = ST_NORM;
        end else if (sts.k_big) begin
          kind_nxt  = bf16rem_pkg::RES_DIVISOR;
          state_nxt = ST_FIN;
        end else begin
          cmd.eng_load_mb = 1'b1;
          kind_nxt        = bf16rem_pkg::RES_ENGINE;
          state_nxt       = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (sts.shift_done) state_nxt = ST_SUB;
        else cmd.shift = 1'b1;
      end
      ST_SUB: begin
        cmd.sub   = 1'b1;
        state_nxt = ST_NORM;
      end
      ST_NORM: begin
        if (sts.norm_done) state_nxt = ST_FIN;
        else cmd.norm = 1'b1;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // hold the result word until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kind_r      <= bf16rem_pkg::RES_SPECIAL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/core/bf16rem_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf16rem_dp - datapath of the bfloat16 remainder unit
// Operand registers, one-bit-a-cycle remainder, shift/subtract add path,
// normalising shifter, double rounding and the output register.
// ----------------------------------------------------------------------------
module bf16rem_dp (
  input  logic                 clk,
  input  logic                 in_opcode,
  input  logic [15:0]          in_dividend,
  input  logic [15:0]          in_divisor,
  output logic [15:0]          out_remainder,
  input  bf16rem_pkg::dp_cmd_t cmd,
  output bf16rem_pkg::dp_sts_t sts
);

  localparam int DW = bf16rem_pkg::DW;

  logic          op_r;
  logic [15:0]   a_r, b_r;
  logic [7:0]    r_r, r_nxt;
  logic [7:0]    sh_r, sh_nxt;
  logic [8:0]    cnt_r, cnt_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [8:0]    e_r, e_nxt;
  logic          s_r, s_nxt;
  logic [15:0]   out_r;

  // operand decode
  logic        sa, sb;
  logic [14:0] aa, ab;
  logic [7:0]  ea, eb, ma, mb;
  logic        a_ge_b;
  logic [7:0]  gap, k;
  logic [7:0]  ur_e;
  logic        spec_nan;
  logic [15:0] spec_val;

  assign sa     = a_r[15];
  assign sb     = b_r[15];
  assign aa     = a_r[14:0];
  assign ab     = b_r[14:0];
  assign ea     = (a_r[14:7] == 8'd0) ? 8'd1 : a_r[14:7];
  assign eb     = (b_r[14:7] == 8'd0) ? 8'd1 : b_r[14:7];
  assign ma     = (a_r[14:7] == 8'd0) ? {1'b0, a_r[6:0]} : {1'b1, a_r[6:0]};
  assign mb     = (b_r[14:7] == 8'd0) ? {1'b0, b_r[6:0]} : {1'b1, b_r[6:0]};
  assign a_ge_b = (aa >= ab);
  assign gap    = ea - eb;
  assign k      = eb - ea;
  assign ur_e   = a_ge_b ? eb : ea;

  // NaN, infinite dividend, zero divisor, infinite divisor, zero dividend
  assign spec_nan = (aa > bf16rem_pkg::INF_MAG) || (ab > bf16rem_pkg::INF_MAG) ||
                    (aa == bf16rem_pkg::INF_MAG) || (ab == 15'd0);
  always_comb begin
    if (spec_nan) spec_val = bf16rem_pkg::QNAN;
    else if (ab == bf16rem_pkg::INF_MAG) begin
      if (!op_r || (aa == 15'd0) || (sa == sb)) spec_val = a_r;
      else spec_val = {sb, bf16rem_pkg::INF_MAG};
    end else spec_val = a_r;
  end

  // one remainder step: bring down next dividend bit, subtract if it fits
  logic [8:0] rr;
  always_comb begin
    rr = {r_r, sh_r[7]};
    if (rr >= {1'b0, mb}) rr = rr - {1'b0, mb};
  end

  // double rounding: 24 bits then 8 bits, nearest even
  logic [24:0] q24;
  logic [23:0] t24;
  logic [8:0]  q8;
  logic [7:0]  m_fin;
  logic [8:0]  e_fin;
  logic [15:0] eng_val;
  always_comb begin
    q24 = {1'b0, d_r[48:25]} +
          {24'd0, d_r[24] & ((|d_r[23:0]) | d_r[25])};
    t24 = q24[23:0];
    q8  = {1'b0, t24[23:16]} + {8'd0, t24[15] & ((|t24[14:0]) | t24[16])};
    if (q24[24] || q8[8]) begin
      m_fin = 8'h80;
      e_fin = e_r + 9'd1;
    end else begin
      m_fin = q8[7:0];
      e_fin = e_r;
    end
    if (!m_fin[7]) eng_val = {s_r, 8'd0, m_fin[6:0]};
    else if (e_fin >= 9'd255) eng_val = {s_r, bf16rem_pkg::INF_MAG};
    else eng_val = {s_r, e_fin[7:0], m_fin[6:0]};
  end

  // status to the controller
  always_comb begin
    sts.special    = spec_nan || (ab == bf16rem_pkg::INF_MAG) || (aa == 15'd0);
    sts.rem_done   = (cnt_r == 9'd0);
    sts.mr_zero    = (r_r == 8'd0);
    sts.need_add   = op_r && (sa != sb);
    sts.k_big      = !a_ge_b && ({1'b0, k} > bf16rem_pkg::MAX_SHIFT);
    sts.shift_done = (cnt_r == 9'd0);
    sts.norm_done  = d_r[DW-1] || (e_r == 9'd1);
  end

  // advance the working registers
  always_comb begin
    r_nxt   = r_r;
    sh_nxt  = sh_r;
    cnt_nxt = cnt_r;
    d_nxt   = d_r;
    e_nxt   = e_r;
    s_nxt   = s_r;
    if (cmd.rem_init) begin
      if (a_ge_b) begin
        r_nxt   = 8'd0;
        sh_nxt  = ma;
        cnt_nxt = {1'b0, gap} + 9'd8;
      end else begin
        r_nxt   = ma;
        cnt_nxt = 9'd0;
      end
    end
    if (cmd.rem_step) begin
      r_nxt   = rr[7:0];
      sh_nxt  = {sh_r[6:0], 1'b0};
      cnt_nxt = cnt_r - 9'd1;
    end
    if (cmd.eng_load_mr) begin
      d_nxt = {{(DW-8){1'b0}}, r_r};
      e_nxt = {1'b0, ur_e} + bf16rem_pkg::TOP_OFS;
      s_nxt = sa;
    end
    if (cmd.eng_load_mb) begin
      d_nxt   = {{(DW-8){1'b0}}, mb};
      e_nxt   = {1'b0, ur_e} + bf16rem_pkg::TOP_OFS;
      s_nxt   = sb;
      cnt_nxt = a_ge_b ? 9'd0 : {1'b0, k};
    end
    if (cmd.shift) begin
      d_nxt   = {d_r[DW-2:0], 1'b0};
      cnt_nxt = cnt_r - 9'd1;
    end
    if (cmd.sub) d_nxt = d_r - {{(DW-8){1'b0}}, r_r};
    if (cmd.norm) begin
      d_nxt = {d_r[DW-2:0], 1'b0};
      e_nxt = e_r - 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_opcode;
      a_r  <= in_dividend;
      b_r  <= in_divisor;
    end
    r_r   <= r_nxt;
    sh_r  <= sh_nxt;
    cnt_r <= cnt_nxt;
    d_r   <= d_nxt;
    e_r   <= e_nxt;
    s_r   <= s_nxt;
  end

  // select and hold the result word
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.res_sel)
        bf16rem_pkg::RES_SPECIAL: out_r <= spec_val;
        bf16rem_pkg::RES_ZERO:    out_r <= {sa, 15'd0};
        bf16rem_pkg::RES_DIVISOR: out_r <= b_r;
        bf16rem_pkg::RES_ENGINE:  out_r <= eng_val;
        default:                  out_r <= bf16rem_pkg::QNAN;
      endcase
    end
  end

  assign out_remainder = out_r;

endmodule

// File: rtl/core/bf16_remainder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf16_remainder_unit - bfloat16 fmod / modulo
// Top level: sequencer and datapath of the remainder unit.
// ----------------------------------------------------------------------------
// One word at a time. The remainder is formed one dividend bit per cycle,
// 8 plus the exponent difference bits in all (up to 261, none when the
// dividend is the smaller); the divisor add for opcode 1 with operands of
// unlike sign shifts one bit per cycle (up to 40) and normalisation moves
// one bit per cycle (up to 48). A special operand skips all of these.
// A finished word sits in the output register, so the next word is taken as
// soon as the previous result has moved there.
module bf16_remainder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [15:0] in_dividend,
  input  logic [15:0] in_divisor,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_remainder
);

  bf16rem_pkg::dp_cmd_t cmd;
  bf16rem_pkg::dp_sts_t sts;

  bf16rem_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bf16rem_dp u_dp (
    .clk           (clk),
    .in_opcode     (in_opcode),
    .in_dividend   (in_dividend),
    .in_divisor    (in_divisor),
    .out_remainder (out_remainder),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

// File: sim/bf16_remainder_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf16_remainder_unit_test - self-checking bench of the bfloat16 remainder unit
// A directed table (special operands, extremes, both opcodes) runs first,
// followed by random operand pairs biased towards close exponents. Every result is
// checked against the row's expected value where one is given, else an integer-exact
// fmod / modulo predictor, with random idling on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module bf16_remainder_unit_test;

  localparam int N_RANDOM   = 800;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_LEN   = 600;
  localparam logic OP_MOD    = 1'b0;
  localparam logic OP_MODULO = 1'b1;

  typedef struct {
    logic        op;
    logic [15:0] a;
    logic [15:0] b;
    bit          has_exp;
    logic [15:0] exp_rem;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_opcode;
  logic [15:0] in_dividend;
  logic [15:0] in_divisor;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_remainder;

  // typed expectation riding along with the current word, if any
  bit          word_has_exp;
  logic [15:0] word_exp;

  logic [15:0] rem_pending[$];
  int          n_errors = 0;
  int          idle_cycles = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  bf16_remainder_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_dividend(in_dividend), .in_divisor(in_divisor),
    .out_valid(out_valid), .out_stall(out_stall), .out_remainder(out_remainder)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic int bit_len(longint unsigned x);
    int n;
    n = 0;
    while (x != 0) begin
      n++;
      x >>= 1;
    end
    return n;
  endfunction

  // round m * 2^u to p bits, unit not below 2^umin, nearest even
  function automatic void round_ne(inout longint unsigned m, inout int u,
                                   input int p, input int umin);
    int tgt, s;
    longint unsigned q, r, half;
    if (m == 0) return;
    tgt = u + bit_len(m) - p;
    if (tgt < umin) tgt = umin;
    if (tgt <= u) return;
    s = tgt - u;
    if (s >= 63) begin
      m = 0;
      u = tgt;
      return;
    end
    q = m >> s;
    r = m & ((64'd1 << s) - 1);
    half = 64'd1 << (s - 1);
    if (r > half || (r == half && q[0])) q++;
    m = q;
    u = tgt;
  endfunction

  function automatic logic [15:0] pack_bf16(logic s, longint unsigned m, int u);
    int e;
    if (m == 0) return {s, 15'd0};
    while (m >= 256) begin
      m >>= 1;
      u++;
    end
    while (m < 128 && u > -133) begin
      m <<= 1;
      u--;
    end
    if (m >= 128) begin
      e = u + 134;
      if (e >= 255) return {s, bf16rem_pkg::INF_MAG};
      return {s, e[7:0], m[6:0]};
    end
    return {s, 8'd0, m[6:0]};
  endfunction

  function automatic logic [15:0] predict_remainder(logic op, logic [15:0] a,
                                                    logic [15:0] b);
    logic            sa, sb;
    logic [14:0]     aa, ab;
    longint unsigned ma, mb, mr, d;
    int              ua, ub, ur, k, u;
    sa = a[15];
    sb = b[15];
    aa = a[14:0];
    ab = b[14:0];
    if (aa >= bf16rem_pkg::INF_MAG || ab > bf16rem_pkg::INF_MAG || ab == 0)
      return bf16rem_pkg::QNAN;
    if (ab == bf16rem_pkg::INF_MAG) begin
      if (op == OP_MOD || aa == 0 || sa == sb) return a;
      return {sb, bf16rem_pkg::INF_MAG};
    end
    if (aa == 0) return a;
    ma = (aa[14:7] != 0) ? {1'b1, aa[6:0]} : aa[6:0];
    ua = ((aa[14:7] != 0) ? int'(aa[14:7]) : 1) - 134;
    mb = (ab[14:7] != 0) ? {1'b1, ab[6:0]} : ab[6:0];
    ub = ((ab[14:7] != 0) ? int'(ab[14:7]) : 1) - 134;
    if (aa < ab) begin
      mr = ma;
      ur = ua;
    end else begin
      // long division, one dividend bit per step
      mr = ma % mb;
      for (int i = 0; i < ua - ub; i++) mr = (mr << 1) % mb;
      ur = ub;
    end
    if (mr == 0) return {sa, 15'd0};
    if (op == OP_MOD || sa == sb) return pack_bf16(sa, mr, ur);
    k = ub - ur;
    if (k > 40) return pack_bf16(sb, mb, ub);
    d = (mb << k) - mr;
    u = ur;
    round_ne(d, u, 24, -149);
    round_ne(d, u, 8, -133);
    return pack_bf16(sb, d, u);
  endfunction

  // ------------------------------------------------- scoreboard and watchdog
  always @(posedge clk) begin
    logic [15:0] want;
    if (rst_n) begin
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles = 0;
      else idle_cycles++;
      // check the oldest result first, then log the new word
      if (out_valid && !out_stall) begin
        if (rem_pending.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result %h", out_remainder);
        end else begin
          want = rem_pending.pop_front();
          if (out_remainder !== want) begin
            n_errors++;
            if (n_errors <= 10)
              $display("remainder mismatch: expected %h got %h", want, out_remainder);
          end
        end
      end
      if (in_valid && !in_stall)
        rem_pending.push_back(word_has_exp ? word_exp
                              : predict_remainder(in_opcode, in_dividend, in_divisor));
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ----------------------------------------------------------------- receiver
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------- sender
  // offer one word and hold it until accepted; called at a rising edge
  task automatic send_word(logic op, logic [15:0] a, logic [15:0] b,
                           bit has_exp, logic [15:0] exp_rem);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_dividend  <= a;
    in_divisor   <= b;
    word_has_exp <= has_exp;
    word_exp     <= exp_rem;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // random bfloat16 pair, mostly with close exponents so the remainder is busy
  task automatic rand_operands(output logic [15:0] a, output logic [15:0] b);
    int eb, ea;
    a = 16'($urandom_range(0, 16'hFFFF));
    b = 16'($urandom_range(0, 16'hFFFF));
    case ($urandom_range(0, 9))
      0, 1: ;
      2: begin
        b[14:7] = 8'd0;
        if ($urandom_range(0, 1)) a[14:7] = 8'd0;
      end
      3: case ($urandom_range(0, 3))
        0: a[14:0] = bf16rem_pkg::INF_MAG;
        1: b[14:0] = bf16rem_pkg::INF_MAG;
        2: a[14:0] = 15'd0;
        default: b[14:0] = 15'd0;
      endcase
      default: begin
        eb = $urandom_range(1, 240);
        ea = eb + $urandom_range(0, 12) - 2;
        if (ea < 0) ea = 0;
        if (ea > 254) ea = 254;
        a[14:7] = ea[7:0];
        b[14:7] = eb[7:0];
      end
    endcase
  endtask

  dir_row_t dir_rows[] = '{
    '{OP_MOD,    16'h7FC1, 16'h3F80, 1'b1, bf16rem_pkg::QNAN},  // NaN dividend
    '{OP_MODULO, 16'h3F80, 16'hFFFF, 1'b1, bf16rem_pkg::QNAN},  // NaN divisor
    '{OP_MOD,    16'h7F80, 16'h3F80, 1'b1, bf16rem_pkg::QNAN},  // infinite dividend
    '{OP_MODULO, 16'hFF80, 16'h7F80, 1'b1, bf16rem_pkg::QNAN},
    '{OP_MOD,    16'h3F80, 16'h0000, 1'b1, bf16rem_pkg::QNAN},  // zero divisor
    '{OP_MODULO, 16'h3F80, 16'h8000, 1'b1, bf16rem_pkg::QNAN},
    '{OP_MOD,    16'hBF80, 16'h7F80, 1'b1, 16'hBF80},           // infinite divisor
    '{OP_MODULO, 16'h3F80, 16'h7F80, 1'b1, 16'h3F80},
    '{OP_MODULO, 16'hBF80, 16'h7F80, 1'b1, 16'h7F80},
    '{OP_MODULO, 16'h3F80, 16'hFF80, 1'b1, 16'hFF80},
    '{OP_MODULO, 16'h8000, 16'hFF80, 1'b1, 16'h8000},
    '{OP_MOD,    16'h8000, 16'h3F80, 1'b1, 16'h8000},           // zero dividend
    '{OP_MODULO, 16'h0000, 16'hBF80, 1'b1, 16'h0000},
    '{OP_MOD,    16'h4000, 16'h3F80, 1'b1, 16'h0000},           // zero remainder
    '{OP_MODULO, 16'hC000, 16'h3F80, 1'b1, 16'h8000},
    '{OP_MOD,    16'h3FC0, 16'h3F80, 1'b1, 16'h3F00},
    '{OP_MODULO, 16'hBFC0, 16'h3F80, 1'b1, 16'h3F00},
    '{OP_MOD,    16'h7F7F, 16'h0001, 1'b0, 16'h0000},           // widest exponent gap
    '{OP_MODULO, 16'hFF7F, 16'h0003, 1'b0, 16'h0000},
    '{OP_MODULO, 16'h0001, 16'hFF7F, 1'b0, 16'h0000},           // tiny remainder, big divisor
    '{OP_MODULO, 16'h8001, 16'h3F80, 1'b0, 16'h0000},
    '{OP_MOD,    16'h7F7F, 16'h7F7E, 1'b0, 16'h0000},
    '{OP_MODULO, 16'hFFFF & 16'h807F, 16'h007F, 1'b0, 16'h0000},
    '{OP_MODULO, 16'h4049, 16'hC000, 1'b0, 16'h0000}
  };

  initial begin
    logic [15:0] a, b;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_opcode    = 1'b0;
    in_dividend  = 16'd0;
    in_divisor   = 16'd0;
    word_has_exp = 1'b0;
    word_exp     = 16'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i])
      send_word(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b,
                dir_rows[i].has_exp, dir_rows[i].exp_rem);

    // random words, with one long output hold-off and one drain pause
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 200) hold_req = 1'b1;
      if (n == 400) begin
        in_valid <= 1'b0;
        @(posedge clk);
        wait (rem_pending.size() == 0);
        @(posedge clk);
      end
      if (n == N_RANDOM - 100) quiet = 1'b1;
      rand_operands(a, b);
      send_word(1'($urandom_range(0, 1)), a, b, 1'b0, 16'd0);
    end
    in_valid <= 1'b0;

    // drain, then let any stray result show up
    @(posedge clk);
    wait (rem_pending.size() == 0);
    repeat (500) @(posedge clk);
    if (n_errors == 0 && rem_pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
